// ===== design/npcs_pkg.sv =====
`default_nettype none

package npcs_pkg;

	// palette geometry
	localparam int PAL_ENTRIES = 256;
	localparam int PAL_AW      = $clog2(PAL_ENTRIES);

	// three squared 8-bit differences: max 3*255^2 fits in 18 bits
	localparam int DIST_W = 18;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_MATCH = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} req_t;

	typedef struct packed {
		logic [7:0] found_index;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} rsp_t;

	// microprogram step addresses
	typedef enum logic [2:0] {
		UPC_IDLE    = 3'd0,
		UPC_WR      = 3'd1,
		UPC_RD_ADDR = 3'd2,
		UPC_RD_OUT  = 3'd3,
		UPC_M_SCAN  = 3'd4,
		UPC_M_SQ    = 3'd5,
		UPC_M_CMP   = 3'd6,
		UPC_M_OUT   = 3'd7
	} upc_t;

	typedef enum logic [1:0] {
		COND_NEXT      = 2'd0,
		COND_DISPATCH  = 2'd1,
		COND_SCAN_MORE = 2'd2,
		COND_OUT_BUSY  = 2'd3
	} cond_t;

	// one control word
	typedef struct packed {
		logic  accept;
		logic  mem_wr;
		logic  rd_idx;
		logic  rd_scan;
		logic  scan_clr;
		logic  out_load;
		logic  out_match;
		cond_t cond;
		upc_t  nxt;
		upc_t  alt;
	} uop_t;

	// datapath status back to the sequencer
	typedef struct packed {
		logic scan_more;
		logic out_free;
	} sts_t;

	localparam logic [7:0] LVL8 [8] = '{8'd0, 8'd32, 8'd64, 8'd128,
		8'd160, 8'd192, 8'd224, 8'd255};
	localparam logic [7:0] LVL4 [4] = '{8'd0, 8'd64, 8'd128, 8'd255};

	// 3-3-2 power-up color of an entry: {red, green, blue}
	function automatic logic [23:0] dflt_color(input logic [7:0] i);
		return {LVL8[i[2:0]], LVL8[i[5:3]], LVL4[i[7:6]]};
	endfunction

endpackage

`default_nettype wire

// ===== design/npcs_useq.sv =====
`default_nettype none

module npcs_useq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	input  wire logic [1:0]      command,
	input  wire npcs_pkg::sts_t  sts,
	output npcs_pkg::uop_t       uop
);

	npcs_pkg::upc_t upc_q;
	npcs_pkg::upc_t upc_d;

	// control store
	function automatic npcs_pkg::uop_t rom(input npcs_pkg::upc_t pc);
		npcs_pkg::uop_t w;
		w = '0;
		w.cond = npcs_pkg::COND_NEXT;
		w.nxt  = npcs_pkg::UPC_IDLE;
		w.alt  = npcs_pkg::UPC_IDLE;
		case (pc)
			npcs_pkg::UPC_IDLE: begin
				w.accept   = 1'b1;
				w.scan_clr = 1'b1;
				w.cond     = npcs_pkg::COND_DISPATCH;
			end
			npcs_pkg::UPC_WR: begin
				w.mem_wr = 1'b1;
			end
			npcs_pkg::UPC_RD_ADDR: begin
				w.rd_idx = 1'b1;
				w.nxt    = npcs_pkg::UPC_RD_OUT;
			end
			npcs_pkg::UPC_RD_OUT: begin
				w.out_load = 1'b1;
				w.cond     = npcs_pkg::COND_OUT_BUSY;
				w.alt      = npcs_pkg::UPC_RD_OUT;
			end
			npcs_pkg::UPC_M_SCAN: begin
				w.rd_scan = 1'b1;
				w.cond    = npcs_pkg::COND_SCAN_MORE;
				w.nxt     = npcs_pkg::UPC_M_SQ;
				w.alt     = npcs_pkg::UPC_M_SCAN;
			end
			npcs_pkg::UPC_M_SQ: begin
				w.nxt = npcs_pkg::UPC_M_CMP;
			end
			npcs_pkg::UPC_M_CMP: begin
				w.nxt = npcs_pkg::UPC_M_OUT;
			end
			npcs_pkg::UPC_M_OUT: begin
				w.out_load  = 1'b1;
				w.out_match = 1'b1;
				w.cond      = npcs_pkg::COND_OUT_BUSY;
				w.alt       = npcs_pkg::UPC_M_OUT;
			end
			default: begin
				w.nxt = npcs_pkg::UPC_IDLE;
			end
		endcase
		return w;
	endfunction

	always_comb begin
		uop = rom(upc_q);
	end

	always_comb begin
		upc_d = uop.nxt;
		case (uop.cond)
			npcs_pkg::COND_NEXT: begin
				upc_d = uop.nxt;
			end
			npcs_pkg::COND_DISPATCH: begin
				if (req_valid) begin
					case (command)
						npcs_pkg::CMD_WRITE: upc_d = npcs_pkg::UPC_WR;
						npcs_pkg::CMD_MATCH: upc_d = npcs_pkg::UPC_M_SCAN;
						npcs_pkg::CMD_READ:  upc_d = npcs_pkg::UPC_RD_ADDR;
						default:             upc_d = npcs_pkg::UPC_IDLE;
					endcase
				end
			end
			npcs_pkg::COND_SCAN_MORE: begin
				upc_d = sts.scan_more ? uop.alt : uop.nxt;
			end
			npcs_pkg::COND_OUT_BUSY: begin
				upc_d = sts.out_free ? uop.nxt : uop.alt;
			end
			default: begin
				upc_d = uop.nxt;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= npcs_pkg::UPC_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/npcs_dpath.sv =====
`default_nettype none

module npcs_dpath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire npcs_pkg::uop_t  uop,
	input  wire logic            req_valid,
	input  wire npcs_pkg::req_t  req,
	output npcs_pkg::sts_t       sts,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output npcs_pkg::rsp_t       rsp
);

	localparam int AW = npcs_pkg::PAL_AW;
	localparam int N  = npcs_pkg::PAL_ENTRIES;

	// captured item
	logic [7:0] idx_q;
	logic [7:0] red_q;
	logic [7:0] green_q;
	logic [7:0] blue_q;

	// palette store; vld_q marks entries overwritten since reset
	logic [23:0]  mem [N];
	logic [N-1:0] vld_q;

	logic          in_rng;
	logic          wr_en;
	logic          rd_en;
	logic [AW-1:0] raddr;
	logic [AW-1:0] ptr_q;

	logic [23:0]   rdat_s1;
	logic          vld_s1;
	logic [AW-1:0] addr_s1;
	logic          scan_s1;
	logic [23:0]   entry;

	logic [15:0]   sqr_s2;
	logic [15:0]   sqg_s2;
	logic [15:0]   sqb_s2;
	logic [AW-1:0] addr_s2;
	logic          scan_s2;

	logic [npcs_pkg::DIST_W-1:0] dist_sum;
	logic [npcs_pkg::DIST_W-1:0] best_d_q;
	logic [AW-1:0]               best_idx_q;

	logic        rsp_valid_q;
	npcs_pkg::rsp_t rsp_q;
	logic        out_free;
	logic        out_ld;

	function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	always_ff @(posedge clk) begin
		if (req_valid && uop.accept) begin
			idx_q   <= req.index;
			red_q   <= req.red;
			green_q <= req.green;
			blue_q  <= req.blue;
		end
	end

	assign in_rng = 32'(idx_q) < N;
	assign wr_en  = uop.mem_wr && in_rng;
	assign rd_en  = uop.rd_idx || uop.rd_scan;
	assign raddr  = uop.rd_scan ? ptr_q : idx_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx_q[AW-1:0]] <= {red_q, green_q, blue_q};
		end
		if (rd_en) begin
			rdat_s1 <= mem[raddr];
			addr_s1 <= raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vld_s1  <= 1'b0;
			scan_s1 <= 1'b0;
			scan_s2 <= 1'b0;
			ptr_q   <= '0;
		end else begin
			if (wr_en) begin
				vld_q[idx_q[AW-1:0]] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= vld_q[raddr];
			end
			scan_s1 <= uop.rd_scan;
			scan_s2 <= scan_s1;
			if (uop.scan_clr) begin
				ptr_q <= '0;
			end else if (uop.rd_scan) begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	// untouched entries read as their power-up color
	assign entry = vld_s1 ? rdat_s1 : npcs_pkg::dflt_color(8'(addr_s1));

	always_ff @(posedge clk) begin
		sqr_s2  <= 16'(absdiff(entry[23:16], red_q)) * 16'(absdiff(entry[23:16], red_q));
		sqg_s2  <= 16'(absdiff(entry[15:8], green_q)) * 16'(absdiff(entry[15:8], green_q));
		sqb_s2  <= 16'(absdiff(entry[7:0], blue_q)) * 16'(absdiff(entry[7:0], blue_q));
		addr_s2 <= addr_s1;
	end

	assign dist_sum = npcs_pkg::DIST_W'(sqr_s2) + npcs_pkg::DIST_W'(sqg_s2)
		+ npcs_pkg::DIST_W'(sqb_s2);

	// strict less-than keeps the lowest index on a tie
	always_ff @(posedge clk) begin
		if (uop.scan_clr) begin
			best_d_q   <= '1;
			best_idx_q <= '0;
		end else if (scan_s2 && (dist_sum < best_d_q)) begin
			best_d_q   <= dist_sum;
			best_idx_q <= addr_s2;
		end
	end

	assign out_free = !rsp_valid_q || rsp_ready;
	assign out_ld   = uop.out_load && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_ld) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			if (uop.out_match) begin
				rsp_q.found_index <= 8'(best_idx_q);
				rsp_q.out_red     <= '0;
				rsp_q.out_green   <= '0;
				rsp_q.out_blue    <= '0;
			end else begin
				rsp_q.found_index <= idx_q;
				rsp_q.out_red     <= in_rng ? entry[23:16] : 8'd0;
				rsp_q.out_green   <= in_rng ? entry[15:8] : 8'd0;
				rsp_q.out_blue    <= in_rng ? entry[7:0] : 8'd0;
			end
		end
	end

	assign sts.scan_more = ptr_q != AW'(N - 1);
	assign sts.out_free  = out_free;
	assign rsp_valid     = rsp_valid_q;
	assign rsp           = rsp_q;

endmodule

`default_nettype wire

// ===== design/nearest_palette_color_search_core.sv =====
// Each command runs its own routine; a new item is not taken until the routine of the last
// one has finished. A match scans every palette entry, one palette read per cycle on a
// single port, so the scan sets the match time.
// A new item is taken while a finished result still waits in the output register.
// Reset (arst_n low, async) returns the sequencer to idle and clears the entry-written
// flags, so the palette reads back as the 3-3-2 default at once with no clearing pass.
`default_nettype none

module nearest_palette_color_search_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire npcs_pkg::req_t  req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output npcs_pkg::rsp_t       rsp
);

	// Microcoded control: the sequencer steps through a small control store.
	// Idle step takes an item and dispatches on its command; write, read and
	// match each run a short routine.  The match routine loops on one step,
	// issuing one palette read per cycle, then drains the two-stage distance
	// pipe (squares, then sum and compare) before loading the result.
	npcs_pkg::uop_t uop;
	npcs_pkg::sts_t sts;

	npcs_useq u_useq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.command   (req.command),
		.sts       (sts),
		.uop       (uop)
	);

	// Palette memory, distance pipe, best-so-far tracker, output register.
	npcs_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.uop       (uop),
		.req_valid (req_valid),
		.req       (req),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// Items are taken only in the idle step.
	assign req_ready = uop.accept;

endmodule

`default_nettype wire

// ===== design/npcs_chk.sv =====
`default_nettype none

module npcs_chk (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            req_valid,
	input wire logic            req_ready,
	input wire npcs_pkg::req_t  req,
	input wire logic            rsp_valid,
	input wire logic            rsp_ready,
	input wire npcs_pkg::rsp_t  rsp
);

	logic acc;
	assign acc = req_valid && req_ready;

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// a write makes no result
	a_wr_silent: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.command == npcs_pkg::CMD_WRITE && !rsp_valid |=> !rsp_valid)
		else $error("write produced a result");

	// with the output free at accept, the read result shows up after the address and output steps, echoing its index
	a_rd_echo: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.command == npcs_pkg::CMD_READ && !rsp_valid
		|-> ##3 (rsp_valid && rsp.found_index == $past(req.index, 3)))
		else $error("read result missing or wrong index");

	// no new item while a match scans
	a_match_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.command == npcs_pkg::CMD_MATCH |=> !req_ready)
		else $error("item taken during match");

endmodule

bind nearest_palette_color_search_core npcs_chk u_chk (.*);

`default_nettype wire

// ===== test/nearest_palette_color_search_core_tb.sv =====
`default_nettype none

module nearest_palette_color_search_core_tb;

	// ------------------------------------------------------------------
	// clock, reset, DUT ports
	// ------------------------------------------------------------------
	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	npcs_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	npcs_pkg::rsp_t rsp;

	nearest_palette_color_search_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// single reset at start
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------
	// palette model and expected-result store
	// ------------------------------------------------------------------
	// an expected result typed in by hand overrides the model's one
	typedef struct packed {
		logic           pinned;
		npcs_pkg::rsp_t value;
	} pin_t;

	typedef struct packed {
		npcs_pkg::req_t item;
		pin_t           pin;
	} probe_t;

	logic [23:0]    pal_model [npcs_pkg::PAL_ENTRIES];  // {red, green, blue}
	npcs_pkg::rsp_t awaited_rsp [$];                    // results still due from the DUT
	pin_t           pin_q [$];                          // one per offered item, in order

	int failures  = 0;
	int rsp_count = 0;
	int n_write   = 0;
	int n_match   = 0;
	int n_read    = 0;
	int n_nop     = 0;

	// power-up 3-3-2 layout: red from bits 2:0, green from 5:3, blue from 7:6
	initial begin
		for (int i = 0; i < npcs_pkg::PAL_ENTRIES; i++)
			pal_model[i] = {npcs_pkg::LVL8[i % 8], npcs_pkg::LVL8[(i / 8) % 8],
				npcs_pkg::LVL4[(i / 64) % 4]};
	end

	// Apply one item to the palette model. Returns 1 when the item yields
	// a result, which is left in res.
	function automatic bit palette_lookup_step(input npcs_pkg::req_t it,
		output npcs_pkg::rsp_t res);
		int          dr;
		int          dg;
		int          db;
		int unsigned sq_dist;
		int unsigned best_dist;
		int          best;
		res = '0;
		case (npcs_pkg::cmd_t'(it.command))
			npcs_pkg::CMD_WRITE: begin
				if (int'(it.index) < npcs_pkg::PAL_ENTRIES)
					pal_model[it.index] = {it.red, it.green, it.blue};
				return 1'b0;
			end
			npcs_pkg::CMD_MATCH: begin
				best      = 0;
				best_dist = 32'hFFFF_FFFF;
				for (int i = 0; i < npcs_pkg::PAL_ENTRIES; i++) begin
					dr      = int'(pal_model[i][23:16]) - int'(it.red);
					dg      = int'(pal_model[i][15:8])  - int'(it.green);
					db      = int'(pal_model[i][7:0])   - int'(it.blue);
					sq_dist = dr * dr + dg * dg + db * db;
					// strict less-than: lowest index keeps a tie
					if (sq_dist < best_dist) begin
						best_dist = sq_dist;
						best      = i;
					end
				end
				res.found_index = 8'(best);
				return 1'b1;
			end
			npcs_pkg::CMD_READ: begin
				res.found_index = it.index;
				if (int'(it.index) < npcs_pkg::PAL_ENTRIES)
					{res.out_red, res.out_green, res.out_blue} = pal_model[it.index];
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// monitor: predict on input accept, check on output accept
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		pin_t           pin;
		npcs_pkg::rsp_t pred;
		npcs_pkg::rsp_t want;
		bit             made;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				pin  = pin_q.pop_front();
				made = palette_lookup_step(req, pred);
				case (npcs_pkg::cmd_t'(req.command))
					npcs_pkg::CMD_WRITE: n_write++;
					npcs_pkg::CMD_MATCH: n_match++;
					npcs_pkg::CMD_READ:  n_read++;
					default:             n_nop++;
				endcase
				if (made)
					awaited_rsp.push_back(pin.pinned ? pin.value : pred);
			end
			if (rsp_valid && rsp_ready) begin
				rsp_count++;
				if (awaited_rsp.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("ERROR: result with nothing pending: idx=%0d rgb=%0d,%0d,%0d",
							rsp.found_index, rsp.out_red, rsp.out_green, rsp.out_blue);
				end else begin
					want = awaited_rsp.pop_front();
					if (rsp.found_index !== want.found_index || rsp.out_red !== want.out_red ||
						rsp.out_green !== want.out_green || rsp.out_blue !== want.out_blue) begin
						failures++;
						if (failures <= 10)
							$display("ERROR: result %0d exp idx=%0d rgb=%0d,%0d,%0d got idx=%0d rgb=%0d,%0d,%0d",
								rsp_count, want.found_index, want.out_red, want.out_green,
								want.out_blue, rsp.found_index, rsp.out_red, rsp.out_green,
								rsp.out_blue);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver: stall modes that change after spans of random length, plus two
	// long hold-offs so the output register and sequencer back up
	// ------------------------------------------------------------------
	initial begin : receiver
		int mode;
		int span;
		int holds_done;
		holds_done = 0;
		@(posedge clk iff arst_n);
		forever begin
			if (holds_done < 2 && rsp_count >= (holds_done == 0 ? 60 : 600)) begin
				@(posedge clk);
				rsp_ready <= 1'b0;
				repeat (900) @(posedge clk);
				holds_done++;
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 200);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					0:       rsp_ready <= 1'b1;                        // no stalls
					1:       rsp_ready <= 1'($urandom_range(0, 1));
					2:       rsp_ready <= ($urandom_range(0, 3) == 0); // mostly stalled
					default: rsp_ready <= ~rsp_ready;                  // alternating
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// sender
	// ------------------------------------------------------------------
	int burst_left = 0;

	// Offer one item; gaps come between bursts of random length. Called
	// in the time step of a rising edge, returns in the step of accept.
	task automatic offer(input npcs_pkg::req_t it, input pin_t pin);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		pin_q.push_back(pin);
		req_valid <= 1'b1;
		req       <= it;
		do @(posedge clk); while (!req_ready);
		burst_left--;
	endtask

	function automatic probe_t row(input npcs_pkg::cmd_t c, input int idx, input int r,
		input int g, input int b, input bit pinned = 1'b0, input int fi = 0,
		input int fr = 0, input int fg = 0, input int fb = 0);
		probe_t p;
		p.item.command     = c;
		p.item.index       = 8'(idx);
		p.item.red         = 8'(r);
		p.item.green       = 8'(g);
		p.item.blue        = 8'(b);
		p.pin.pinned       = pinned;
		p.pin.value        = {8'(fi), 8'(fr), 8'(fg), 8'(fb)};
		return p;
	endfunction

	// channel value biased toward extremes, palette levels and the
	// midpoints between levels (where ties between entries show up)
	function automatic logic [7:0] pick_channel();
		int k;
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			1: return npcs_pkg::LVL8[$urandom_range(0, 7)];
			2: begin
				k = $urandom_range(0, 6);
				return 8'((int'(npcs_pkg::LVL8[k]) + int'(npcs_pkg::LVL8[k + 1])) / 2);
			end
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin : stimulus
		probe_t         dir_rows [$];
		npcs_pkg::req_t it;
		int             sel;
		int             offered;
		dir_rows = '{
			// power-up palette contents
			row(npcs_pkg::CMD_READ,    0,   0,   0,   0, 1,   0,   0,   0,   0),
			row(npcs_pkg::CMD_READ,  255,   0,   0,   0, 1, 255, 255, 255, 255),
			row(npcs_pkg::CMD_READ,  146,   0,   0,   0, 1, 146,  64,  64, 128),
			row(npcs_pkg::CMD_MATCH,  77,   0,   0,   0, 1,   0,   0,   0,   0),
			row(npcs_pkg::CMD_MATCH,   0, 255, 255, 255, 1, 255,   0,   0,   0),
			// the first is equidistant from several entries on every channel
			row(npcs_pkg::CMD_MATCH,   0,  16,  16,  32),
			row(npcs_pkg::CMD_MATCH, 200, 100, 200,  90),
			// overwrite both ends; white at 0 and 255 ties, lowest wins
			row(npcs_pkg::CMD_WRITE,   0, 255, 255, 255),
			row(npcs_pkg::CMD_READ,    0,   0,   0,   0, 1,   0, 255, 255, 255),
			row(npcs_pkg::CMD_MATCH,   9, 255, 255, 255, 1,   0,   0,   0,   0),
			row(npcs_pkg::CMD_WRITE, 255,   0,   0,   0),
			row(npcs_pkg::CMD_MATCH,   0,   0,   0,   0, 1, 255,   0,   0,   0),
			row(npcs_pkg::CMD_READ,  255, 255, 255, 255, 1, 255,   0,   0,   0),
			// unused command must not write and must not answer
			row(npcs_pkg::CMD_NOP,     0,   0,   0,   0),
			row(npcs_pkg::CMD_READ,    0,   0,   0,   0, 1,   0, 255, 255, 255),
			row(npcs_pkg::CMD_NOP,   255, 255, 255, 255),
			row(npcs_pkg::CMD_WRITE, 128,  18,  52,  86),
			row(npcs_pkg::CMD_READ,  128,   0,   0,   0, 1, 128,  18,  52,  86),
			row(npcs_pkg::CMD_MATCH,  33,  19,  51,  87),
			// pure green now at 1, 2 and 56: three-way tie
			row(npcs_pkg::CMD_WRITE,   1,   0, 255,   0),
			row(npcs_pkg::CMD_WRITE,   2,   0, 255,   0),
			row(npcs_pkg::CMD_MATCH,   0,   0, 250,   0, 1,   1,   0,   0,   0),
			row(npcs_pkg::CMD_READ,    2,   0,   0,   0, 1,   2,   0, 255,   0)
		};

		@(posedge clk iff arst_n);
		foreach (dir_rows[i])
			offer(dir_rows[i].item, dir_rows[i].pin);

		// random part; ignored commands are not counted
		offered = 0;
		while (offered < 1500) begin
			// once midway: stop and let every pending result come back
			if (offered == 750) begin
				req_valid <= 1'b0;
				@(posedge clk);
				while (awaited_rsp.size() != 0) @(posedge clk);
				burst_left = 0;
			end
			sel   = $urandom_range(0, 99);
			it    = '0;
			it.index = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
				: 8'($urandom_range(0, 255));
			{it.red, it.green, it.blue} = {pick_channel(), pick_channel(), pick_channel()};
			if (sel < 5) begin
				it.command = npcs_pkg::CMD_NOP;
				{it.red, it.green, it.blue} = 24'($urandom);
			end else if (sel < 40) begin
				it.command = npcs_pkg::CMD_WRITE;
				// duplicate colors make ties on later matches
				if ($urandom_range(0, 3) == 0)
					{it.red, it.green, it.blue} =
						pal_model[$urandom_range(0, npcs_pkg::PAL_ENTRIES - 1)];
			end else if (sel < 70) begin
				it.command = npcs_pkg::CMD_MATCH;
				if ($urandom_range(0, 2) == 0)
					{it.red, it.green, it.blue} =
						pal_model[$urandom_range(0, npcs_pkg::PAL_ENTRIES - 1)];
				else if ($urandom_range(0, 3) == 0)
					{it.red, it.green, it.blue} = 24'($urandom);
			end else begin
				it.command = npcs_pkg::CMD_READ;
			end
			offer(it, '0);
			if (sel >= 5)
				offered++;
		end
		req_valid <= 1'b0;

		// drain, then watch a full match time for stray results
		@(posedge clk);
		while (awaited_rsp.size() != 0) @(posedge clk);
		repeat (npcs_pkg::PAL_ENTRIES + 8) @(posedge clk);

		$display("Covered %0d writes, %0d matches, %0d reads, %0d unused commands;",
			n_write, n_match, n_read, n_nop);
		$display("%0d results checked, %0d mismatches", rsp_count, failures);
		if (failures == 0 && awaited_rsp.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// watchdog: far beyond an all-match run with worst stalls
	initial begin
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ===== nearest_palette_color_search_core.f =====
design/npcs_pkg.sv
design/npcs_useq.sv
design/npcs_dpath.sv
design/nearest_palette_color_search_core.sv
design/npcs_chk.sv
test/nearest_palette_color_search_core_tb.sv
